[rtl/mti_pkg.sv]
// Shared types and constants of the monotonic table interpolator.
package mti_pkg;

    localparam int DATA_W        = 32;
    localparam int ENTRY_INDEX_W = 7;
    localparam int CFG_W         = 8;

    localparam logic [CFG_W-1:0] CFG_ENTRIES_RESET = 8'd128;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef struct packed {
        logic                            action;
        logic [ENTRY_INDEX_W-1:0]        entry_index;
        logic signed [DATA_W-1:0]        entry_key;
        logic signed [DATA_W-1:0]        entry_value;
        logic signed [DATA_W-1:0]        query_key;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]        interpolated_value;
        logic [ENTRY_INDEX_W-1:0]        segment_index;
        logic signed [DATA_W-1:0]        segment_fraction;
        logic                            extrapolated;
        logic                            degenerate_segment;
        logic                            saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_IND,
        ST_RD_HI,
        ST_OPER,
        ST_PREP,
        ST_DIV,
        ST_QFIX,
        ST_MUL,
        ST_SUM,
        ST_VAL,
        ST_OUT
    } state_t;

endpackage

[rtl/monotonic_table_interpolator.sv]
// Monotonic key/value table with binary search and linear interpolation per query.
//
// A load transfer writes one key/value entry and returns no result.
// A query runs through a sequencer around the key and value memories, each with one
// synchronous read port: two reads settle the table direction, the binary search then
// reads and then compares in each halving step, at most floor(log2 n) + 1 of them, and
// ends with a closing read, two more reads fetch the segment ends, a restoring divider
// produces the fraction one quotient bit per cycle, in Q16.16 for the default
// FRACTION_BITS, and a split multiplier forms the value. A stalled result holds the
// sequencer in its output state. A degenerate segment skips the divider and multiplier.
// The result waits in an output register, so loads are taken while it is pending.
// No clearing pass is run after reset.
module monotonic_table_interpolator #(
    parameter int TABLE_DEPTH   = 128,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  mti_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output mti_pkg::out_item_t        m_data,
    input  logic                      cfg_wr_en,
    input  logic [mti_pkg::CFG_W-1:0] cfg_wr_data
);
    import mti_pkg::*;

    localparam int IW   = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int FB   = FRACTION_BITS;
    localparam int NUMW = 33 + FB;
    localparam int DCW  = $clog2(NUMW);

    localparam logic [NUMW-1:0] POS_LIM = {{(NUMW-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic [NUMW-1:0] NEG_LIM = {{(NUMW-32){1'b0}}, 32'h8000_0000};

    logic [31:0] key_mem [TABLE_DEPTH];
    logic [31:0] val_mem [TABLE_DEPTH];

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  entries_in_use_reg;
    logic [CW-1:0]     n_cfg;
    logic [CW-1:0]     n_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [IW-1:0]     rd_addr;
    logic [31:0]       key_rdata_reg;
    logic [31:0]       val_rdata_reg;
    logic              out_load;

    logic signed [31:0] q_reg;
    logic signed [31:0] k_first_reg;
    logic              asc_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     half_w;
    logic [CW-1:0]     mid_w;
    logic              before_w;
    logic [CW-1:0]     ind_w;
    logic [CW-1:0]     ind_reg;
    logic              extrap_reg;
    logic signed [31:0] k0_reg;
    logic signed [31:0] v0_reg;
    logic signed [32:0] diff_reg;
    logic signed [32:0] den_reg;
    logic signed [32:0] dv_reg;
    logic              degen_reg;
    logic [32:0]       diff_mag_w;
    logic [32:0]       den_mag_w;
    logic [32:0]       den_mag_reg;
    logic              neg_reg;
    logic [NUMW-1:0]   num_sh_reg;
    logic [32:0]       rem_reg;
    logic [33:0]       rem_sh_w;
    logic              qbit_w;
    logic [DCW-1:0]    div_cnt_reg;
    logic signed [31:0] frac_reg;
    logic signed [31:0] val_res_reg;
    logic              sat_reg;
    logic signed [48:0] ph_reg;
    logic signed [48:0] pl_reg;
    logic signed [64:0] prod_reg;
    logic signed [64:0] prod_sh_w;
    logic signed [65:0] val_full_w;
    logic              val_ovf_w;
    out_item_t         result_w;

    // Configuration register and the clamped entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_in_use_reg <= CFG_ENTRIES_RESET;
        end else if (cfg_wr_en) begin
            entries_in_use_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (32'(entries_in_use_reg) < 32'd2) begin
            n_cfg = CW'(2);
        end else if (32'(entries_in_use_reg) > 32'(TABLE_DEPTH)) begin
            n_cfg = CW'(TABLE_DEPTH);
        end else begin
            n_cfg = CW'(entries_in_use_reg);
        end
    end

    // Table memories: one write port from load transfers, one registered read port.
    assign mem_we    = s_valid && s_ready && (s_data.action == ACTION_LOAD) &&
                       (32'(s_data.entry_index) < 32'(TABLE_DEPTH));
    assign mem_waddr = IW'(s_data.entry_index);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_waddr] <= s_data.entry_key;
            val_mem[mem_waddr] <= s_data.entry_value;
        end
        key_rdata_reg <= key_mem[rd_addr];
        val_rdata_reg <= val_mem[rd_addr];
    end

    // Search step and segment selection.
    assign half_w = cnt_reg >> 1;
    assign mid_w  = lo_reg + half_w;
    assign before_w = asc_reg ? ($signed(key_rdata_reg) < q_reg)
                              : ($signed(key_rdata_reg) > q_reg);

    always_comb begin
        if (lo_reg == '0) begin
            ind_w = CW'(1);
        end else if (lo_reg >= n_reg) begin
            ind_w = n_reg - CW'(1);
        end else begin
            ind_w = lo_reg;
        end
    end

    // Divider and value arithmetic.
    assign diff_mag_w = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
    assign den_mag_w  = den_reg[32]  ? 33'(-den_reg)  : 33'(den_reg);
    assign rem_sh_w   = {rem_reg, num_sh_reg[NUMW-1]};
    assign qbit_w     = (rem_sh_w >= {1'b0, den_mag_reg});

    // Arithmetic shift right is the floor of the division by two to the FB.
    assign prod_sh_w  = prod_reg >>> FB;
    assign val_full_w = 66'(prod_sh_w) + 66'(v0_reg);
    assign val_ovf_w  = !((&val_full_w[65:31]) || !(|val_full_w[65:31]));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_data.action == ACTION_QUERY) begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:    state_next = ST_LAST;
            ST_LAST:     state_next = ST_SRCH_RD;
            ST_SRCH_RD:  state_next = (cnt_reg == '0) ? ST_IND : ST_SRCH_CMP;
            ST_SRCH_CMP: state_next = ST_SRCH_RD;
            ST_IND:      state_next = ST_RD_HI;
            ST_RD_HI:    state_next = ST_OPER;
            ST_OPER:     state_next = ST_PREP;
            ST_PREP:     state_next = degen_reg ? ST_OUT : ST_DIV;
            ST_DIV:      state_next = (div_cnt_reg == DCW'(NUMW - 1)) ? ST_QFIX : ST_DIV;
            ST_QFIX:     state_next = ST_MUL;
            ST_MUL:      state_next = ST_SUM;
            ST_SUM:      state_next = ST_VAL;
            ST_VAL:      state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready, memory read address, result load.
    always_comb begin
        s_ready  = 1'b0;
        rd_addr  = '0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_FIRST:   rd_addr = IW'(n_reg - CW'(1));
            ST_SRCH_RD: rd_addr = mid_w[IW-1:0];
            ST_IND:     rd_addr = IW'(ind_w - CW'(1));
            ST_RD_HI:   rd_addr = ind_reg[IW-1:0];
            ST_OUT:     out_load = !m_valid_reg || m_ready;
            default:    rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Query datapath; the read in the idle cycle returns the first key.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                q_reg <= s_data.query_key;
                n_reg <= n_cfg;
            end
            ST_FIRST: begin
                k_first_reg <= $signed(key_rdata_reg);
            end
            ST_LAST: begin
                asc_reg <= $signed(key_rdata_reg) > k_first_reg;
                lo_reg  <= '0;
                cnt_reg <= n_reg;
            end
            ST_SRCH_CMP: begin
                if (before_w) begin
                    lo_reg  <= mid_w + CW'(1);
                    cnt_reg <= cnt_reg - half_w - CW'(1);
                end else begin
                    cnt_reg <= half_w;
                end
            end
            ST_IND: begin
                ind_reg    <= ind_w;
                extrap_reg <= (lo_reg >= n_reg) || (lo_reg == '0 && q_reg != k_first_reg);
            end
            ST_RD_HI: begin
                k0_reg <= $signed(key_rdata_reg);
                v0_reg <= $signed(val_rdata_reg);
            end
            ST_OPER: begin
                diff_reg  <= 33'(q_reg) - 33'(k0_reg);
                den_reg   <= 33'($signed(key_rdata_reg)) - 33'(k0_reg);
                dv_reg    <= 33'($signed(val_rdata_reg)) - 33'(v0_reg);
                degen_reg <= (key_rdata_reg == k0_reg);
            end
            ST_PREP: begin
                frac_reg    <= '0;
                val_res_reg <= v0_reg;
                sat_reg     <= 1'b0;
                num_sh_reg  <= {diff_mag_w, {FB{1'b0}}};
                den_mag_reg <= den_mag_w;
                neg_reg     <= diff_reg[32] ^ den_reg[32];
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV: begin
                // Quotient bits shift in behind the numerator bits that leave.
                if (qbit_w) begin
                    rem_reg <= 33'(rem_sh_w - {1'b0, den_mag_reg});
                end else begin
                    rem_reg <= rem_sh_w[32:0];
                end
                num_sh_reg  <= {num_sh_reg[NUMW-2:0], qbit_w};
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
            ST_QFIX: begin
                if (!neg_reg && num_sh_reg > POS_LIM) begin
                    frac_reg <= 32'sh7FFF_FFFF;
                    sat_reg  <= 1'b1;
                end else if (neg_reg && num_sh_reg > NEG_LIM) begin
                    frac_reg <= 32'sh8000_0000;
                    sat_reg  <= 1'b1;
                end else if (neg_reg) begin
                    frac_reg <= $signed(~num_sh_reg[31:0] + 32'd1);
                end else begin
                    frac_reg <= $signed(num_sh_reg[31:0]);
                end
            end
            ST_MUL: begin
                ph_reg <= 49'(frac_reg) * 49'($signed(dv_reg[32:16]));
                pl_reg <= 49'(frac_reg) * 49'($signed({1'b0, dv_reg[15:0]}));
            end
            ST_SUM: begin
                prod_reg <= (65'(ph_reg) <<< 16) + 65'(pl_reg);
            end
            ST_VAL: begin
                if (val_ovf_w) begin
                    val_res_reg <= val_full_w[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    sat_reg     <= 1'b1;
                end else begin
                    val_res_reg <= val_full_w[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_comb begin
        result_w.interpolated_value = val_res_reg;
        result_w.segment_index      = ENTRY_INDEX_W'(ind_reg);
        result_w.segment_fraction   = frac_reg;
        result_w.extrapolated       = extrap_reg;
        result_w.degenerate_segment = degen_reg;
        result_w.saturated          = sat_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result_w;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/mti_checker.sv]
// Port-level assertions for the monotonic table interpolator and their bind.
module mti_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mti_pkg::in_item_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input mti_pkg::out_item_t  m_data
);
    import mti_pkg::*;

    // A stalled result stays offered unchanged.
    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data))
    ) else $error("result changed or dropped while stalled");

    // Reset empties the output register.
    a_reset_clears: assert property (
        @(posedge aclk)
        !aresetn |=> !m_valid
    ) else $error("result valid right after reset");

    // No transfer, load or query, produces a result in the following cycle.
    a_no_instant_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid
    ) else $error("result appeared one cycle after an input transfer");

    // A degenerate segment reports the left entry with a zero fraction and no saturation.
    a_degenerate_fields: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate_segment) |->
            (m_data.segment_fraction == '0 && !m_data.saturated)
    ) else $error("degenerate segment with nonzero fraction or saturation");

endmodule

bind monotonic_table_interpolator mti_checker u_mti_checker (.*);

[tb/sv/monotonic_table_interpolator_tb.sv]
// Self-checking testbench for the monotonic table interpolator: loads, queries and table sizes.
module monotonic_table_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mti_pkg::*;

    localparam int     TABLE_DEPTH  = 128;
    localparam int     FRAC_BITS    = 16;
    localparam int     CLK_HALF_NS  = 6;
    localparam int     RESET_CYCLES = 5;
    localparam int     DRAIN_CYCLES = 120;
    localparam int     RANDOM_ITEMS = 2000;
    localparam int     QUIET_TAIL   = 300;
    localparam int     REPORT_LIMIT = 10;
    localparam longint CYCLE_LIMIT  = 1000000;
    localparam longint WORD_MAX     = 64'sd2147483647;
    localparam longint WORD_MIN     = -64'sd2147483648;

    typedef enum int {
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_PLATEAU,
        SHAPE_FLAT,
        SHAPE_SCRAMBLED
    } table_shape_e;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_item_t          s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_item_t         m_data;
    logic              cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;

    // Table contents and size as the block sees them; the contents follow each accepted load.
    logic signed [DATA_W-1:0] key_mem   [TABLE_DEPTH];
    logic signed [DATA_W-1:0] value_mem [TABLE_DEPTH];
    int unsigned              entries_cfg = 32'(CFG_ENTRIES_RESET);

    // Table as the stimulus generator plans it, ahead of the block.
    longint      plan_keys [TABLE_DEPTH];
    int unsigned plan_entries;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];

    bit     idle_on = 1'b1;
    int     src_gap;
    int     sink_gap;
    int     error_count;
    int     random_items;
    int     loads_sent;
    int     queries_checked;
    int     extrap_seen;
    int     degen_seen;
    int     sat_seen;
    int     settings_applied;
    longint cycle_count;

    monotonic_table_interpolator dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    function automatic longint clip_word(input longint v, output bit hit);
        hit = 1'b0;
        if (v > WORD_MAX) begin
            hit = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            hit = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // Lower-bound search over the used entries, then interpolation on the chosen segment.
    function automatic out_item_t interpolate(input logic signed [DATA_W-1:0] q_word);
        out_item_t   r;
        int unsigned n, lo, cnt, half, mid, seg;
        longint      q, k0, k1, v0, v1, frac, val;
        bit          rising, ahead, hit, sat;
        n = entries_cfg;
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        q = longint'(q_word);
        rising = key_mem[n-1] > key_mem[0];
        lo = 0;
        cnt = n;
        while (cnt > 0) begin
            half = cnt / 2;
            mid = lo + half;
            ahead = rising ? (longint'(key_mem[mid]) < q) : (longint'(key_mem[mid]) > q);
            if (ahead) begin
                lo = mid + 1;
                cnt -= half + 1;
            end else begin
                cnt = half;
            end
        end
        if (lo == 0) seg = 1;
        else if (lo >= n) seg = n - 1;
        else seg = lo;
        k0 = longint'(key_mem[seg-1]);
        k1 = longint'(key_mem[seg]);
        v0 = longint'(value_mem[seg-1]);
        v1 = longint'(value_mem[seg]);
        r = '0;
        sat = 1'b0;
        r.extrapolated = (lo >= n) || (lo == 0 && q != longint'(key_mem[0]));
        if (k1 == k0) begin
            r.degenerate_segment = 1'b1;
            frac = 0;
            val = v0;
        end else begin
            frac = clip_word((q - k0) * (longint'(1) << FRAC_BITS) / (k1 - k0), hit);
            sat |= hit;
            // The arithmetic shift floors, as the value rounding requires.
            val = clip_word(v0 + ((frac * (v1 - v0)) >>> FRAC_BITS), hit);
            sat |= hit;
        end
        r.interpolated_value = val[DATA_W-1:0];
        r.segment_index      = seg[ENTRY_INDEX_W-1:0];
        r.segment_fraction   = frac[DATA_W-1:0];
        r.saturated          = sat;
        return r;
    endfunction

    task automatic take_transfer(input in_item_t it);
        if (it.action == ACTION_LOAD) begin
            key_mem[it.entry_index]   = it.entry_key;
            value_mem[it.entry_index] = it.entry_value;
        end else begin
            expected_results.insert(expected_results.size(), interpolate(it.query_key));
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        bit        bad;
        if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("ERROR: result with no query pending: value=%0d seg=%0d frac=%0d",
                         got.interpolated_value, got.segment_index, got.segment_fraction);
        end else begin
            want = expected_results.pop_front();
            queries_checked++;
            extrap_seen += want.extrapolated;
            degen_seen  += want.degenerate_segment;
            sat_seen    += want.saturated;
            bad = (got.interpolated_value !== want.interpolated_value)
               || (got.segment_index      !== want.segment_index)
               || (got.segment_fraction   !== want.segment_fraction)
               || (got.extrapolated       !== want.extrapolated)
               || (got.degenerate_segment !== want.degenerate_segment)
               || (got.saturated          !== want.saturated);
            if (bad) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("ERROR: query %0d expected val=%0d seg=%0d frac=%0d x=%b d=%b s=%b",
                             queries_checked, want.interpolated_value, want.segment_index,
                             want.segment_fraction, want.extrapolated,
                             want.degenerate_segment, want.saturated);
                    $display("       got            val=%0d seg=%0d frac=%0d x=%b d=%b s=%b",
                             got.interpolated_value, got.segment_index, got.segment_fraction,
                             got.extrapolated, got.degenerate_segment, got.saturated);
                end
            end
        end
    endtask

    // Source side: one transfer per handshake, with random idle bursts between them while idling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_transfer(s_data);
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0 && idle_on
                             && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 3);
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: checks each result transfer and, while idling is on, stalls in random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("monotonic_table_interpolator_tb: FAIL");
            $finish;
        end
    end

    task automatic queue_load(input int unsigned idx, input longint key, input longint val);
        in_item_t it;
        it.action      = ACTION_LOAD;
        it.entry_index = idx[ENTRY_INDEX_W-1:0];
        it.entry_key   = key[DATA_W-1:0];
        it.entry_value = val[DATA_W-1:0];
        it.query_key   = $urandom;
        plan_keys[idx] = longint'(it.entry_key);
        pending_items.insert(pending_items.size(), it);
        loads_sent++;
    endtask

    task automatic queue_query(input longint q);
        in_item_t it;
        it.action      = ACTION_QUERY;
        it.entry_index = ENTRY_INDEX_W'($urandom);
        it.entry_key   = $urandom;
        it.entry_value = $urandom;
        it.query_key   = q[DATA_W-1:0];
        pending_items.insert(pending_items.size(), it);
    endtask

    // Waits until every transfer is taken and every result is back, then lets the block settle.
    task automatic wait_for_idle();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_entries(input int unsigned count);
        wait_for_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count[CFG_W-1:0];
        entries_cfg = count & 8'hFF;
        plan_entries = (entries_cfg < 2) ? 2 : (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH
                                                                              : entries_cfg;
        settings_applied++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic build_table(input table_shape_e shape);
        longint      key, val, step_cap, step;
        int unsigned i, value_mode;
        bit          hit;
        key = longint'($signed($urandom)) >>> $urandom_range(0, 31);
        val = longint'($signed($urandom)) >>> $urandom_range(0, 31);
        step_cap = longint'(1) << $urandom_range(0, 24);
        value_mode = $urandom_range(0, 2);
        for (i = 0; i < plan_entries; i++) begin
            if (i != 0) begin
                step = $urandom_range(1, int'(step_cap));
                if (shape == SHAPE_PLATEAU && $urandom_range(0, 2) == 0) step = 0;
                case (shape)
                    SHAPE_FALLING:   key = clip_word(key - step, hit);
                    SHAPE_FLAT:      key = key;
                    SHAPE_SCRAMBLED: key = longint'($signed($urandom)) >>> $urandom_range(0, 16);
                    default:         key = clip_word(key + step, hit);
                endcase
                case (value_mode)
                    0: val = longint'($signed($urandom));
                    1: val = clip_word(val + (longint'($signed($urandom)) >>> 12), hit);
                    default: val = longint'($signed($urandom)) >>> 11;
                endcase
            end
            queue_load(i, key, val);
        end
    endtask

    task automatic queue_random_query();
        int unsigned seg;
        longint      lo_key, hi_key, q;
        bit          hit;
        seg = $urandom_range(1, plan_entries - 1);
        lo_key = plan_keys[seg-1];
        hi_key = plan_keys[seg];
        case ($urandom_range(0, 9))
            5: q = plan_keys[$urandom_range(0, plan_entries - 1)];
            6: q = clip_word(plan_keys[0] - (longint'($urandom) >> $urandom_range(0, 31)), hit);
            7: q = clip_word(plan_keys[plan_entries-1]
                             + (longint'($urandom) >> $urandom_range(0, 31)), hit);
            8: q = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            9: q = longint'($signed($urandom));
            default: q = lo_key + ((hi_key - lo_key) * longint'($urandom_range(0, 1024))) / 1024;
        endcase
        queue_query(q);
    endtask

    initial begin
        int unsigned  phase, count, queries, i;
        int unsigned  preset [12] = '{2, 128, 0, 255, 1, 129, 3, 5, 16, 17, 64, 127};
        table_shape_e shape;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Four-entry table with the key and value extremes; the bottom segment has equal keys.
        set_entries(4);
        queue_load(0, WORD_MIN, WORD_MAX);
        queue_load(1, WORD_MIN, 0);
        queue_load(2, 0, WORD_MIN);
        queue_load(3, WORD_MAX, WORD_MAX);
        queue_load(127, WORD_MAX, WORD_MIN);
        queue_query(WORD_MIN);
        queue_query(WORD_MAX);
        queue_query(1);
        queue_query(-1);

        // Short last segment and a steep first one drive the fraction and value into clipping.
        queue_load(0, 0, 0);
        queue_load(1, 65536, 6553600);
        queue_load(2, 131072, -65536);
        queue_load(3, 131073, WORD_MAX);
        queue_query(WORD_MIN);
        queue_query(WORD_MAX);
        queue_query(131072);
        queue_query(98304);

        // Falling keys.
        queue_load(0, 196608, 10);
        queue_load(1, 131072, -20);
        queue_load(2, 65536, 30);
        queue_load(3, 0, -40);
        queue_query(327680);
        queue_query(-327680);
        queue_query(98304);

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            // One round adds at most 278 items, so the final round always runs without idling.
            if (random_items > RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            count = (phase < 12) ? preset[phase] : $urandom_range(2, TABLE_DEPTH);
            set_entries(count);
            shape = table_shape_e'($urandom_range(0, 4));
            build_table(shape);
            random_items += plan_entries;
            queries = $urandom_range(50, 150);
            for (i = 0; i < queries; i++) begin
                // Now and then an entry is overwritten with arbitrary content.
                if ($urandom_range(0, 12) == 0) begin
                    queue_load($urandom_range(0, TABLE_DEPTH - 1), longint'($signed($urandom)),
                               longint'($signed($urandom)));
                end else begin
                    queue_random_query();
                end
            end
            random_items += queries;
            phase++;
        end

        wait_for_idle();
        $display("Covered %0d table sizes, %0d loads and %0d checked queries.",
                 settings_applied, loads_sent, queries_checked);
        $display("Queries outside the table: %0d, on equal-key segments: %0d, clipped: %0d.",
                 extrap_seen, degen_seen, sat_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("monotonic_table_interpolator_tb: PASS");
        end else begin
            $display("monotonic_table_interpolator_tb: FAIL");
        end
        $finish;
    end

endmodule
